/* hdl/ahdlc_pkg.sv */
package ahdlc_pkg;

    localparam int MAX_FRAME_LEN = 256;
    localparam int CNT_W         = $clog2(MAX_FRAME_LEN + 1);
    localparam int LEN_W         = 9;
    localparam int TOTAL_W       = 16;

    localparam logic [7:0]  FLAG_BYTE = 8'h7e;
    localparam logic [7:0]  ESC_BYTE  = 8'h7d;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [7:0]  CTRL_LIM  = 8'h20;
    localparam logic [7:0]  ADDR_BYTE = 8'hff;
    localparam logic [7:0]  CTRL_BYTE = 8'h03;
    localparam logic [15:0] FCS_INIT  = 16'hffff;
    localparam logic [15:0] FCS_GOOD  = 16'hf0b8;
    localparam logic [15:0] FCS_POLY  = 16'h8408;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_CRC  = 2'd2,
        KIND_LONG = 2'd3
    } kind_t;

    typedef struct packed {
        logic                 esc;
        logic [CNT_W-1:0]     count;
        logic [15:0]          fcs;
        logic [7:0]           hb0;
        logic [7:0]           hb1;
        logic [1:0]           fill;
        logic [TOTAL_W-1:0]   crc_total;
        logic [TOTAL_W-1:0]   ovf_total;
    } frame_state_t;

    typedef struct packed {
        kind_t                kind;
        logic [7:0]           data;
        logic [LEN_W-1:0]     len;
        logic [TOTAL_W-1:0]   crc_total;
        logic [TOTAL_W-1:0]   ovf_total;
    } result_t;

    // One byte of the reflected FCS-16, bit by bit
    function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] f;
        f = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (f[0])
                f = (f >> 1) ^ FCS_POLY;
            else
                f = f >> 1;
        end
        return f;
    endfunction

    // Clear per-frame state, keep the running totals
    function automatic frame_state_t frame_restart(input frame_state_t s);
        frame_state_t r;
        r       = s;
        r.esc   = 1'b0;
        r.count = '0;
        r.fcs   = FCS_INIT;
        r.hb0   = 8'h00;
        r.hb1   = 8'h00;
        r.fill  = 2'd0;
        return r;
    endfunction

endpackage

/* hdl/ahdlc_step.sv */
module ahdlc_step (
    input  ahdlc_pkg::frame_state_t state,
    input  logic [7:0]              byte_in,
    input  logic                    accept_ctrl,
    output ahdlc_pkg::frame_state_t state_next,
    output logic                    res_valid,
    output ahdlc_pkg::result_t      res
);

    logic [7:0]               c;
    logic                     go;
    ahdlc_pkg::kind_t         kind;
    logic [7:0]               data;
    logic [ahdlc_pkg::LEN_W-1:0] len;

    always_comb
    begin
        state_next = state;
        res_valid  = 1'b0;
        kind       = ahdlc_pkg::KIND_DATA;
        data       = 8'h00;
        len        = '0;
        c          = byte_in;
        go         = 1'b0;

        if (!(byte_in < ahdlc_pkg::CTRL_LIM && !accept_ctrl))
        begin
            if (state.esc)
            begin
                state_next.esc = 1'b0;
                if (byte_in == ahdlc_pkg::FLAG_BYTE)
                begin
                    // abort: drop the frame silently
                    state_next = ahdlc_pkg::frame_restart(state);
                end
                else
                begin
                    c  = byte_in ^ ahdlc_pkg::ESC_XOR;
                    go = 1'b1;
                end
            end
            else if (byte_in == ahdlc_pkg::FLAG_BYTE)
            begin
                state_next = ahdlc_pkg::frame_restart(state);
                if (state.fcs == ahdlc_pkg::FCS_GOOD)
                begin
                    res_valid = 1'b1;
                    kind      = ahdlc_pkg::KIND_GOOD;
                    if (state.count >= ahdlc_pkg::CNT_W'(2))
                        len = ahdlc_pkg::LEN_W'(state.count - ahdlc_pkg::CNT_W'(2));
                end
                else if (state.count > ahdlc_pkg::CNT_W'(3))
                begin
                    res_valid            = 1'b1;
                    kind                 = ahdlc_pkg::KIND_CRC;
                    state_next.crc_total = state.crc_total + ahdlc_pkg::TOTAL_W'(1);
                end
            end
            else if (byte_in == ahdlc_pkg::ESC_BYTE)
            begin
                state_next.esc = 1'b1;
            end
            else
            begin
                go = 1'b1;
            end

            if (go)
            begin
                if (state.count >= ahdlc_pkg::CNT_W'(ahdlc_pkg::MAX_FRAME_LEN))
                begin
                    state_next           = ahdlc_pkg::frame_restart(state);
                    state_next.ovf_total = state.ovf_total + ahdlc_pkg::TOTAL_W'(1);
                    res_valid            = 1'b1;
                    kind                 = ahdlc_pkg::KIND_LONG;
                end
                else
                begin
                    state_next.fcs = ahdlc_pkg::fcs_update(state.fcs, c);
                    // strip leading address and control bytes
                    if (!(state.count == '0 &&
                          (c == ahdlc_pkg::ADDR_BYTE || c == ahdlc_pkg::CTRL_BYTE)))
                    begin
                        state_next.count = state.count + ahdlc_pkg::CNT_W'(1);
                        if (state.fill < 2'd2)
                        begin
                            if (state.fill[0])
                                state_next.hb1 = c;
                            else
                                state_next.hb0 = c;
                            state_next.fill = state.fill + 2'd1;
                        end
                        else
                        begin
                            // advance the holdback and release its oldest byte
                            res_valid      = 1'b1;
                            kind           = ahdlc_pkg::KIND_DATA;
                            data           = state.hb0;
                            state_next.hb0 = state.hb1;
                            state_next.hb1 = c;
                        end
                    end
                end
            end
        end

        res.kind      = kind;
        res.data      = data;
        res.len       = len;
        res.crc_total = state_next.crc_total;
        res.ovf_total = state_next.ovf_total;
    end

endmodule

/* hdl/ahdlc_receive_deframer_core.sv */
// PPP async-HDLC receive deframer.
// Input channel: in_valid / in_stall with one raw line byte on rx_byte.
// Output channel: out_valid / out_stall with kind, data_byte, frame_length,
// crc_errors and overflow_errors; at most one output request per line byte.
// Configuration: cfg_valid / cfg_ready / cfg_data writes accept_control_chars;
// cfg_ready is always high, write only while the block is idle.
// Path: input register, then one pass of unescape, FCS-16 and holdback logic
// into the output register. Throughput: one byte per cycle while no waiting
// output is stalled, set by the single state update pass.
// Payload bytes leave two bytes late, so the FCS bytes are never shown; a
// closing flag gives a good-frame request, or a CRC-error request once more
// than three bytes were counted; an over-long frame gives a too-long request.
// Reset clears the frame state, both error totals and the configuration register.
// When out_stall holds a waiting output, an empty input register still takes one
// more byte; in_stall rises once a byte waits there blocked.
module ahdlc_receive_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [8:0]  frame_length,
    output logic [15:0] crc_errors,
    output logic [15:0] overflow_errors,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    accept_ctrl_reg;
    ahdlc_pkg::frame_state_t state_reg;
    ahdlc_pkg::frame_state_t state_next;
    logic                    out_valid_reg;
    ahdlc_pkg::result_t      out_reg;
    logic                    res_valid;
    ahdlc_pkg::result_t      res;
    logic                    blocked;
    logic                    fire;

    ahdlc_step u_step (
        .state       (state_reg),
        .byte_in     (in_byte_reg),
        .accept_ctrl (accept_ctrl_reg),
        .state_next  (state_next),
        .res_valid   (res_valid),
        .res         (res)
    );

    assign blocked   = out_valid_reg && out_stall;
    assign fire      = in_valid_reg && !blocked;
    assign in_stall  = in_valid_reg && blocked;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            accept_ctrl_reg <= 1'b0;
            state_reg       <= ahdlc_pkg::frame_restart('0);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                accept_ctrl_reg <= cfg_data;
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (fire)
                state_reg <= state_next;
            if (!blocked)
                out_valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_byte_reg <= rx_byte;
        if (!blocked && fire && res_valid)
            out_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign kind            = out_reg.kind;
    assign data_byte       = out_reg.data;
    assign frame_length    = out_reg.len;
    assign crc_errors      = out_reg.crc_total;
    assign overflow_errors = out_reg.ovf_total;

endmodule

/* hdl/ahdlc_checker.sv */
module ahdlc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  data_byte,
    input logic [8:0]  frame_length,
    input logic [15:0] crc_errors,
    input logic [15:0] overflow_errors
);

    // Input backs up only behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("in_stall without a stalled output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte))
        else $error("stalled output changed");

    a_len_only_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != ahdlc_pkg::KIND_GOOD |-> frame_length == '0)
        else $error("frame_length set outside a good frame end");

    // Back-to-back data requests leave both totals untouched
    a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid && !out_stall) && out_valid && kind == ahdlc_pkg::KIND_DATA
        |-> crc_errors == $past(crc_errors) && overflow_errors == $past(overflow_errors))
        else $error("error totals moved on a data request");

endmodule

bind ahdlc_receive_deframer_core ahdlc_checker u_ahdlc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .data_byte       (data_byte),
    .frame_length    (frame_length),
    .crc_errors      (crc_errors),
    .overflow_errors (overflow_errors)
);
